// ===== rtl/rgbgb_pkg.sv =====
`timescale 1ns / 1ps

package rgbgb_pkg;

    // pixel and channel layout: blue in the low byte, red in the high byte
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int CH_MAX = 255;

    // window geometry
    localparam int KERNEL_SIZE = 5;
    localparam int KHALF       = KERNEL_SIZE / 2;
    localparam int LB_LINES    = KERNEL_SIZE - 1;

    // frame size limits and counter widths
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int CFG_SIZE_W  = 12;
    localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int HEIGHT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 3);
    localparam int LEAD_W      = $clog2(2 * MAX_WIDTH + 3);

    // configuration port
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // arithmetic widths
    localparam int COEF_FRAC_BITS = 16;
    localparam int ROUND_HALF     = 1 << (COEF_FRAC_BITS - 1);
    localparam int NUM_CLASSES    = 6;
    localparam int CSUM_W         = CH_W + 3;
    localparam int PROD_W         = COEF_W + CSUM_W;
    localparam int SUM_W          = PROD_W + 3;

    // result queue
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH       = 3'd0,
        REG_IMAGE_HEIGHT      = 3'd1,
        REG_COEF_CORNER       = 3'd2,
        REG_COEF_OUTER_NEAR   = 3'd3,
        REG_COEF_OUTER_MID    = 3'd4,
        REG_COEF_INNER_CORNER = 3'd5,
        REG_COEF_INNER_MID    = 3'd6,
        REG_COEF_CENTER       = 3'd7
    } reg_index_t;

    // weight classes of the symmetric kernel
    typedef enum logic [2:0] {
        CLS_CORNER       = 3'd0,
        CLS_OUTER_NEAR   = 3'd1,
        CLS_OUTER_MID    = 3'd2,
        CLS_INNER_CORNER = 3'd3,
        CLS_INNER_MID    = 3'd4,
        CLS_CENTER       = 3'd5
    } coef_class_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [LB_LINES-1:0][PIX_W-1:0] stack_t;
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_t;
    typedef logic [NUM_CLASSES-1:0][COEF_W-1:0] coef_set_t;

    // per-item control that travels with a pixel
    typedef struct packed {
        logic                   emit;
        logic                   eor;
        logic                   eof;
        logic [KERNEL_SIZE-1:0] row_ok;
        logic [KERNEL_SIZE-1:0] col_ok;
    } item_ctl_t;

    // one finished output pixel
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            eor;
        logic            eof;
    } res_t;

    localparam coef_set_t COEF_RESET = {
        16'd5591, 16'd4477, 16'd3585, 16'd2299, 16'd1841, 16'd945
    };

    localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET  = CFG_SIZE_W'(640);
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET = CFG_SIZE_W'(480);

    // weight class at window tap (row delay j, column delay m)
    function automatic coef_class_t class_of(input int j, input int m);
        int ay;
        int ax;
        int hi;
        int lo;
        coef_class_t c;
        ay = (j > KHALF) ? j - KHALF : KHALF - j;
        ax = (m > KHALF) ? m - KHALF : KHALF - m;
        hi = (ay > ax) ? ay : ax;
        lo = (ay > ax) ? ax : ay;
        if (hi == 2) begin
            if (lo == 2) c = CLS_CORNER;
            else if (lo == 1) c = CLS_OUTER_NEAR;
            else c = CLS_OUTER_MID;
        end else if (hi == 1) begin
            if (lo == 1) c = CLS_INNER_CORNER;
            else c = CLS_INNER_MID;
        end else begin
            c = CLS_CENTER;
        end
        return c;
    endfunction

    // zero acts as one, oversize acts as the maximum
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_SIZE_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v == '0) r = WIDTH_W'(1);
        else if (32'(v) > MAX_WIDTH) r = WIDTH_W'(MAX_WIDTH);
        else r = WIDTH_W'(v);
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_SIZE_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v == '0) r = HEIGHT_W'(1);
        else if (32'(v) > MAX_HEIGHT) r = HEIGHT_W'(MAX_HEIGHT);
        else r = HEIGHT_W'(v);
        return r;
    endfunction

endpackage

// ===== rtl/rgbgb_ram.sv =====
`timescale 1ns / 1ps

module rgbgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rgbgb_ctrl.sv =====
`timescale 1ns / 1ps

module rgbgb_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rgbgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgbgb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 accept,
    output rgbgb_pkg::coef_set_t                 coefs,
    output logic [rgbgb_pkg::COL_W-1:0]          lb_addr,
    output rgbgb_pkg::item_ctl_t                 item_ctl
);

    import rgbgb_pkg::*;

    logic [WIDTH_W-1:0]  width_reg,  width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    coef_set_t           coef_reg,   coef_next;
    logic [COL_W-1:0]    col_reg,    col_next;
    logic [ROW_W-1:0]    row_reg,    row_next;
    logic [LEAD_W-1:0]   lead_reg,   lead_next;
    logic [COL_W-1:0]    ocol_reg,   ocol_next;
    logic [ROW_W-1:0]    orow_reg,   orow_next;

    logic                clear;
    logic [WIDTH_W-1:0]  col_inc;
    logic                col_wrap;
    logic [WIDTH_W-1:0]  ocol_inc;
    logic [ROW_W-1:0]    orow_inc;
    logic [LEAD_W-1:0]   lead_target;
    logic [ROW_W:0]      orow_off;
    logic [WIDTH_W:0]    ocol_off;

    // position arithmetic for the incoming item and the next output
    assign col_inc     = WIDTH_W'(col_reg) + WIDTH_W'(1);
    assign col_wrap    = col_inc >= width_reg;
    assign ocol_inc    = WIDTH_W'(ocol_reg) + WIDTH_W'(1);
    assign orow_inc    = orow_reg + ROW_W'(1);
    assign lead_target = (LEAD_W'(width_reg) << 1) + LEAD_W'(2);
    assign orow_off    = (ROW_W+1)'(orow_reg) + (ROW_W+1)'(KHALF);
    assign ocol_off    = (WIDTH_W+1)'(ocol_reg) + (WIDTH_W+1)'(KHALF);

    // item flags and border masks for the window tap rows and columns
    always_comb
    begin
        item_ctl.emit = lead_reg == lead_target;
        item_ctl.eor  = ocol_inc >= width_reg;
        item_ctl.eof  = item_ctl.eor && (orow_inc >= ROW_W'(height_reg));
        for (int j = 0; j < KERNEL_SIZE; j++)
        begin
            item_ctl.row_ok[j] = (orow_off >= (ROW_W+1)'(j)) &&
                ((orow_off - (ROW_W+1)'(j)) < (ROW_W+1)'(height_reg));
        end
        for (int m = 0; m < KERNEL_SIZE; m++)
        begin
            item_ctl.col_ok[m] = (ocol_off >= (WIDTH_W+1)'(m)) &&
                ((ocol_off - (WIDTH_W+1)'(m)) < (WIDTH_W+1)'(width_reg));
        end
    end

    // register writes and counter advance
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        coef_next   = coef_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        lead_next   = lead_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        clear       = 1'b0;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    width_next = clamp_width(cfg_data[CFG_SIZE_W-1:0]);
                    clear      = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = clamp_height(cfg_data[CFG_SIZE_W-1:0]);
                    clear       = 1'b1;
                end
                REG_COEF_CORNER:       coef_next[CLS_CORNER]       = cfg_data;
                REG_COEF_OUTER_NEAR:   coef_next[CLS_OUTER_NEAR]   = cfg_data;
                REG_COEF_OUTER_MID:    coef_next[CLS_OUTER_MID]    = cfg_data;
                REG_COEF_INNER_CORNER: coef_next[CLS_INNER_CORNER] = cfg_data;
                REG_COEF_INNER_MID:    coef_next[CLS_INNER_MID]    = cfg_data;
                REG_COEF_CENTER:       coef_next[CLS_CENTER]       = cfg_data;
                default: ;
            endcase
        end else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else
            begin
                col_next = COL_W'(col_inc);
            end
            if (!item_ctl.emit)
            begin
                lead_next = lead_reg + LEAD_W'(1);
            end else if (item_ctl.eof)
            begin
                clear = 1'b1;
            end else if (item_ctl.eor)
            begin
                ocol_next = '0;
                orow_next = orow_inc;
            end else
            begin
                ocol_next = COL_W'(ocol_inc);
            end
        end
        // frame restart
        if (clear)
        begin
            col_next  = '0;
            row_next  = '0;
            lead_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_width(WIDTH_RESET);
            height_reg <= clamp_height(HEIGHT_RESET);
            coef_reg   <= COEF_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            lead_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            coef_reg   <= coef_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            lead_reg   <= lead_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    assign coefs   = coef_reg;
    assign lb_addr = col_reg;

endmodule

// ===== rtl/rgbgb_window.sv =====
`timescale 1ns / 1ps

module rgbgb_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  rgbgb_pkg::pix_t             pixel,
    input  logic [rgbgb_pkg::COL_W-1:0] addr,
    input  rgbgb_pkg::item_ctl_t        ctl_in,
    output rgbgb_pkg::win_t             win,
    output rgbgb_pkg::item_ctl_t        win_ctl,
    output logic                        win_valid
);

    import rgbgb_pkg::*;

    logic             s1_valid_reg;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    item_ctl_t        s1_ctl_reg;
    logic             bypass_reg;
    stack_t           last_wr_reg;
    stack_t           ram_rd;
    stack_t           stack;
    stack_t           wr_stack;
    win_t             win_reg;
    item_ctl_t        win_ctl_reg;
    logic             win_valid_reg;

    // four previous rows at this column, one word per column
    rgbgb_ram #(
        .WIDTH ($bits(stack_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_stack),
        .re      (accept),
        .rd_addr (addr),
        .rd_data (ram_rd)
    );

    // forward the word written in the same cycle it was read (one-pixel rows)
    assign stack = bypass_reg ? last_wr_reg : ram_rd;

    // push the new pixel on top, drop the oldest row
    always_comb
    begin
        wr_stack[0] = s1_pix_reg;
        for (int i = 1; i < LB_LINES; i++)
        begin
            wr_stack[i] = stack[i-1];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end else
        begin
            s1_valid_reg  <= accept;
            win_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
        end
    end

    // stage after the line store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_addr_reg <= addr;
            s1_ctl_reg  <= ctl_in;
            bypass_reg  <= s1_valid_reg && (addr == s1_addr_reg);
        end
        if (s1_valid_reg)
        begin
            last_wr_reg <= wr_stack;
        end
    end

    // 5x5 window shift, new column enters at column delay zero
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int j = 0; j < KERNEL_SIZE; j++)
            begin
                for (int m = 1; m < KERNEL_SIZE; m++)
                begin
                    win_reg[j][m] <= win_reg[j][m-1];
                end
            end
            win_reg[0][0] <= s1_pix_reg;
            for (int j = 1; j < KERNEL_SIZE; j++)
            begin
                win_reg[j][0] <= stack[j-1];
            end
            win_ctl_reg <= s1_ctl_reg;
        end
    end

    assign win       = win_reg;
    assign win_ctl   = win_ctl_reg;
    assign win_valid = win_valid_reg;

endmodule

// ===== rtl/rgbgb_mac.sv =====
`timescale 1ns / 1ps

module rgbgb_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 win_valid,
    input  rgbgb_pkg::win_t      win,
    input  rgbgb_pkg::item_ctl_t win_ctl,
    input  rgbgb_pkg::coef_set_t coefs,
    output logic                 res_valid,
    output rgbgb_pkg::res_t      res
);

    import rgbgb_pkg::*;

    typedef logic [NUM_CLASSES-1:0][NUM_CH-1:0][CSUM_W-1:0] csum_t;
    typedef logic [NUM_CLASSES-1:0][NUM_CH-1:0][PROD_W-1:0] prod_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0]                   sum_t;
    typedef logic [NUM_CH-1:0][CH_W-1:0]                    chan_t;

    csum_t csum_next, csum_reg;
    prod_t prod_next, prod_reg;
    sum_t  sum_next,  sum_reg;
    chan_t chan_out;
    logic  csum_valid_reg, prod_valid_reg, sum_valid_reg;
    logic  csum_eor_reg,   prod_eor_reg,   sum_eor_reg;
    logic  csum_eof_reg,   prod_eof_reg,   sum_eof_reg;

    // add up in-frame pixels that share a weight
    always_comb
    begin
        csum_next = '0;
        for (int j = 0; j < KERNEL_SIZE; j++)
        begin
            for (int m = 0; m < KERNEL_SIZE; m++)
            begin
                if (win_ctl.row_ok[j] && win_ctl.col_ok[m])
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        csum_next[class_of(j, m)][ch] = csum_next[class_of(j, m)][ch] +
                            CSUM_W'(win[j][m][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // one multiply per weight class and channel
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                prod_next[c][ch] = PROD_W'(coefs[c]) * PROD_W'(csum_reg[c][ch]);
            end
        end
    end

    // accumulate the class products
    always_comb
    begin
        sum_next = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                sum_next[ch] = sum_next[ch] + SUM_W'(prod_reg[c][ch]);
            end
        end
    end

    // round half up and saturate
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (((sum_reg[ch] + SUM_W'(ROUND_HALF)) >> COEF_FRAC_BITS) > SUM_W'(CH_MAX))
            begin
                chan_out[ch] = CH_W'(CH_MAX);
            end else
            begin
                chan_out[ch] = CH_W'((sum_reg[ch] + SUM_W'(ROUND_HALF)) >> COEF_FRAC_BITS);
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else
        begin
            csum_valid_reg <= win_valid;
            prod_valid_reg <= csum_valid_reg;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        csum_reg     <= csum_next;
        csum_eor_reg <= win_ctl.eor;
        csum_eof_reg <= win_ctl.eof;
        prod_reg     <= prod_next;
        prod_eor_reg <= csum_eor_reg;
        prod_eof_reg <= csum_eof_reg;
        sum_reg      <= sum_next;
        sum_eor_reg  <= prod_eor_reg;
        sum_eof_reg  <= prod_eof_reg;
    end

    assign res_valid = sum_valid_reg;
    assign res.blue  = chan_out[0];
    assign res.green = chan_out[1];
    assign res.red   = chan_out[2];
    assign res.eor   = sum_eor_reg;
    assign res.eof   = sum_eof_reg;

endmodule

// ===== rtl/rgbgb_outq.sv =====
`timescale 1ns / 1ps

module rgbgb_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            reserve,
    input  logic            push,
    input  rgbgb_pkg::res_t push_data,
    output logic            out_valid,
    input  logic            out_stall,
    output rgbgb_pkg::res_t out_data,
    output logic            full
);

    import rgbgb_pkg::*;

    res_t               q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] credit_reg;
    logic               pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = count_reg != '0;
    assign out_data  = q_mem[rd_ptr_reg];

    // a slot is held from the input transfer that yields a result until its output transfer
    assign full = credit_reg == Q_CNT_W'(Q_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg  <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
            credit_reg <= credit_reg + Q_CNT_W'(reserve) - Q_CNT_W'(pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/rgb_gaussian_blur_5x5.sv =====
`timescale 1ns / 1ps

// Streaming 5x5 Gaussian blur of 24-bit BGR pixels, one pixel per clock.
// Pixels enter in raster order; after each frame the source sends
// 2*image_width+2 flush items, which count as zero pixels. The blurred pixel
// for frame position k leaves on the transfer caused by input item
// k + 2*image_width + 2, so the first 2*image_width+2 items of a frame give
// no result. The block takes an input every cycle as long as the output
// side keeps up; the eight-entry result queue covers the pipeline and
// in_stall comes from a registered slot count, so it never follows
// out_stall in the same cycle. Rows are held in one simple dual-port line
// RAM of MAX_WIDTH words of four pixels, read and written once per input.
// Weights are Q0.16, sums round half up and saturate at 255; the frame has
// a two-pixel zero border. Writing image_width or image_height restarts
// the frame. Configure only while the block is idle.

module rgb_gaussian_blur_5x5 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rgbgb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rgbgb_pkg::CH_W-1:0]         blue_in,
    input  logic [rgbgb_pkg::CH_W-1:0]         green_in,
    input  logic [rgbgb_pkg::CH_W-1:0]         red_in,
    input  logic                               flush,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rgbgb_pkg::CH_W-1:0]         blue_out,
    output logic [rgbgb_pkg::CH_W-1:0]         green_out,
    output logic [rgbgb_pkg::CH_W-1:0]         red_out,
    output logic                               end_of_row,
    output logic                               end_of_frame
);

    import rgbgb_pkg::*;

    logic             accept;
    pix_t             pixel;
    coef_set_t        coefs;
    logic [COL_W-1:0] lb_addr;
    item_ctl_t        item_ctl;
    win_t             win;
    item_ctl_t        win_ctl;
    logic             win_valid;
    logic             res_valid;
    res_t             res;
    res_t             q_data;
    logic             q_full;

    // input transfer, flush items enter as zero pixels
    assign accept   = in_valid && !in_stall;
    assign pixel    = flush ? '0 : {red_in, green_in, blue_in};
    assign in_stall = q_full;

    rgbgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .coefs     (coefs),
        .lb_addr   (lb_addr),
        .item_ctl  (item_ctl)
    );

    rgbgb_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pixel     (pixel),
        .addr      (lb_addr),
        .ctl_in    (item_ctl),
        .win       (win),
        .win_ctl   (win_ctl),
        .win_valid (win_valid)
    );

    rgbgb_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win       (win),
        .win_ctl   (win_ctl),
        .coefs     (coefs),
        .res_valid (res_valid),
        .res       (res)
    );

    rgbgb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (accept && item_ctl.emit),
        .push      (res_valid),
        .push_data (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (q_data),
        .full      (q_full)
    );

    // output payload
    assign blue_out     = q_data.blue;
    assign green_out    = q_data.green;
    assign red_out      = q_data.red;
    assign end_of_row   = q_data.eor;
    assign end_of_frame = q_data.eof;

endmodule
